### sv/ofrm_pkg.sv
`default_nettype none
package ofrm_pkg;

	localparam int DEFAULT_CAPACITY = 8;
	localparam int TAG_W            = 16;
	localparam int HEIGHT_W         = 12;
	localparam int HEIGHT_MAX       = 4095;
	localparam int MEAN_W           = 12;
	localparam int STEP_W           = 4;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_POP,
		ST_PREP,
		ST_DIV
	} ofrm_state_t;

endpackage
`default_nettype wire

### sv/ofrm_ram.sv
`default_nettype none
module ofrm_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### sv/overwrite_fifo_rounded_mean.sv
// Insert strobes when the divider finishes (after EVICT when the queue is full and the
// oldest word is evicted first); remove strobes after the RAM read; an empty remove strobes from idle.
// Throughput: one command at a time; busy drops in the strobe cycle, where the next
// command can be taken. The receiver cannot stall, so results never wait.
// Insert runs the 12-step restoring divider; remove waits on the RAM read.
// Reset clears head, tail, count and sum at once; RAM contents stay undefined.
`default_nettype none
module overwrite_fifo_rounded_mean
	import ofrm_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                kind,
	input  wire logic [TAG_W-1:0]    item_tag,
	input  wire logic [HEIGHT_W-1:0] item_height,
	output logic                     done,
	output logic [MEAN_W-1:0]        mean_height,
	output logic [TAG_W-1:0]         removed_tag,
	output logic [HEIGHT_W-1:0]      removed_height,
	output logic                     empty_error
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = $clog2(CAPACITY * HEIGHT_MAX + 1);
	localparam int NUM_W = $clog2(CAPACITY * (2 * HEIGHT_MAX + 1) + 1);
	localparam int REC_W = TAG_W + HEIGHT_W;

	ofrm_state_t state_q, state_d;

	logic [IDX_W-1:0]    head_q, tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TAG_W-1:0]    tag_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [NUM_W-1:0]    rem_q, den_q;
	logic [MEAN_W-1:0]   quot_q;
	logic [STEP_W-1:0]   step_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [REC_W-1:0]    ram_wdata, ram_rdata;
	logic [TAG_W-1:0]    rd_tag;
	logic [HEIGHT_W-1:0] rd_height;

	logic accept, full, empty, fits;
	logic [IDX_W-1:0] head_nx, tail_nx;

	assign accept    = start && !busy;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign empty     = count_q == '0;
	assign head_nx   = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx   = (tail_q == IDX_W'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;
	assign rd_tag    = ram_rdata[REC_W-1:HEIGHT_W];
	assign rd_height = ram_rdata[HEIGHT_W-1:0];
	assign fits      = rem_q >= den_q;

	ofrm_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_INSERT) begin
						state_d = full ? ST_EVICT : ST_PREP;
					end else if (!empty) begin
						state_d = ST_POP;
					end
				end
			end
			ST_EVICT: state_d = ST_PREP;
			ST_POP:   state_d = ST_IDLE;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != ST_IDLE;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {item_tag, item_height};
		unique case (state_q)
			ST_IDLE: ram_we = accept && kind == KIND_INSERT && !full;
			ST_EVICT: begin
				// head and tail coincide here; the head word was read last cycle
				ram_we    = 1'b1;
				ram_wdata = {tag_q, height_q};
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && kind == KIND_INSERT && !full) begin
						tail_q  <= tail_nx;
						count_q <= count_q + 1'b1;
						sum_q   <= sum_q + SUM_W'(item_height);
					end else if (accept && kind == KIND_REMOVE && empty) begin
						done <= 1'b1;
					end
				end
				ST_EVICT: begin
					head_q <= head_nx;
					tail_q <= tail_nx;
					sum_q  <= sum_q + SUM_W'(height_q) - SUM_W'(rd_height);
				end
				ST_POP: begin
					head_q  <= head_nx;
					count_q <= count_q - 1'b1;
					sum_q   <= sum_q - SUM_W'(rd_height);
					done    <= 1'b1;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						done <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tag_q    <= item_tag;
					height_q <= item_height;
				end
				if (accept && kind == KIND_REMOVE && empty) begin
					mean_height    <= '0;
					removed_tag    <= '0;
					removed_height <= '0;
					empty_error    <= 1'b1;
				end
			end
			ST_POP: begin
				mean_height    <= '0;
				removed_tag    <= rd_tag;
				removed_height <= rd_height;
				empty_error    <= 1'b0;
			end
			ST_PREP: begin
				// numerator 2*sum + count, divisor 2*count aligned to the top quotient bit
				rem_q  <= (NUM_W'(sum_q) << 1) + NUM_W'(count_q);
				den_q  <= NUM_W'(count_q) << MEAN_W;
				quot_q <= '0;
				step_q <= STEP_W'(MEAN_W - 1);
			end
			ST_DIV: begin
				if (fits) begin
					rem_q <= rem_q - den_q;
				end
				den_q  <= den_q >> 1;
				quot_q <= {quot_q[MEAN_W-2:0], fits};
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					mean_height    <= {quot_q[MEAN_W-2:0], fits};
					removed_tag    <= '0;
					removed_height <= '0;
					empty_error    <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |=> done && !empty_error)
		else $error("divider finish without mean strobe");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE || state_q == ST_EVICT))
		else $error("RAM write outside insert states");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && empty_error) |-> (count_q == '0 && removed_tag == '0))
		else $error("empty flag raised with records queued");

endmodule
`default_nettype wire
